@@ sv/shce_pkg.sv @@
// shared types, constants and helpers for the spherical harmonics colour evaluator
// no dependencies; imported by every module of the block
`default_nettype none

package shce_pkg;

	localparam int UNIT_W  = 16;   // unit vector components, Q1.14
	localparam int BASIS_W = 16;   // basis values, Q1.14
	localparam int SUM_W   = 36;   // channel accumulators, Q9.26
	localparam int FRAC_W  = 14;
	localparam int OUT_W   = 16;   // rgb result, Q3.12
	localparam int SQ_W    = 15;   // magnitude width after prescaling
	localparam int SS_W    = 32;   // sum of squares
	localparam int RAD_W   = 60;   // sum of squares shifted left by 28
	localparam int ROOT_W  = 30;
	localparam int QUO_W   = 17;
	localparam int NUM_W   = 44;
	localparam int MUL_W   = 18;   // shared basis multiplier operands
	localparam int PRE_SH  = 28;

	localparam logic signed [MUL_W-1:0]   K_C1  = 18'sd8005;
	localparam logic signed [MUL_W-1:0]   K_C20 = 18'sd5167;
	localparam logic signed [MUL_W-1:0]   K_C21 = 18'sd8950;
	localparam logic signed [MUL_W-1:0]   K_C24 = 18'sd4475;
	localparam logic signed [BASIS_W-1:0] K_C0  = 16'sd4622;
	localparam logic [QUO_W-1:0]          UNIT_ONE = 17'd16384;

	localparam logic signed [22:0] OUT_MAX = 23'sd32767;
	localparam logic signed [22:0] OUT_MIN = -23'sd32768;

	localparam int N_BASIS = 9;
	localparam logic REG_DEGREE = 1'b0;
	localparam logic [1:0] DEGREE_RESET = 2'd2;

	typedef enum logic {OP_DIR = 1'b0, OP_COEF = 1'b1} op_t;

	typedef enum logic [1:0] {C_IDLE, C_NORM, C_BASIS, C_EMIT} ctrl_state_t;

	typedef enum logic [2:0] {
		N_IDLE, N_SHIFT, N_SQUARE, N_ROOT, N_DIV_LOAD, N_DIV
	} norm_state_t;

	typedef enum logic [3:0] {
		BS_XX, BS_YY, BS_ZZ, BS_XY, BS_YZ, BS_XZ,
		BS_B1, BS_B2, BS_B3, BS_B4, BS_B5, BS_B6, BS_B7, BS_B8
	} bstep_t;

	typedef struct packed {
		logic   load_dir;
		logic   acc;
		logic   emit;
		logic   bstep_en;
		bstep_t bstep;
	} cmd_t;

	typedef struct packed {
		logic norm_done;
		logic last_coef;
		logic out_free;
	} stat_t;

	// coefficient triples per point for a degree setting
	function automatic logic [3:0] coef_count(input logic [1:0] deg);
		logic [3:0] n;
		case (deg)
			2'd0:    n = 4'd1;
			2'd1:    n = 4'd4;
			default: n = 4'd9;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

@@ sv/shce_norm.sv @@
// direction normalization unit: prescale, sum of squares, bit-serial root, restoring divide
// depends on shce_pkg
`default_nettype none

module shce_norm #(
	parameter int DIR_WIDTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic signed [DIR_WIDTH-1:0]           dir_x,
	input  wire logic signed [DIR_WIDTH-1:0]           dir_y,
	input  wire logic signed [DIR_WIDTH-1:0]           dir_z,
	output logic                                       done,
	output logic signed [shce_pkg::UNIT_W-1:0]         unit_x,
	output logic signed [shce_pkg::UNIT_W-1:0]         unit_y,
	output logic signed [shce_pkg::UNIT_W-1:0]         unit_z
);
	import shce_pkg::*;

	localparam int CNT_W = $clog2(QUO_W);

	norm_state_t state_q, state_d;

	logic [DIR_WIDTH-1:0]     dir_a [3];
	logic [DIR_WIDTH-1:0]     mag_q [3];
	logic                     neg_q [3];
	logic [SQ_W-1:0]          mag15 [3];
	logic signed [UNIT_W-1:0] unit_q [3];
	logic [SS_W-1:0]          ss_q, ss_nxt;
	logic [2*SQ_W-1:0]        sq;
	logic [RAD_W-1:0]         rad_q, root_q, bit_q, trial;
	logic [ROOT_W-1:0]        root;
	logic [ROOT_W-1:0]        rem_q;
	logic [QUO_W-1:0]         num_q, quo_q, quo_fin, quo_clip;
	logic [NUM_W-1:0]         num;
	logic [ROOT_W:0]          div_t, div_r;
	logic                     div_ge;
	logic [CNT_W-1:0]         cnt_q;
	logic [1:0]               idx_q;
	logic                     wide, all_zero, done_q;

	assign dir_a[0] = dir_x;
	assign dir_a[1] = dir_y;
	assign dir_a[2] = dir_z;

	always_comb begin
		wide = 1'b0;
		all_zero = 1'b1;
		for (int i = 0; i < 3; i++) begin
			mag15[i] = SQ_W'(mag_q[i]);
			if ((mag_q[i] >> SQ_W) != '0) wide = 1'b1;
			if (mag_q[i] != '0) all_zero = 1'b0;
		end
	end

	assign sq      = mag15[idx_q] * mag15[idx_q];
	assign ss_nxt  = ss_q + SS_W'(sq);
	assign trial   = root_q + bit_q;
	assign root    = root_q[ROOT_W-1:0];
	assign num     = (NUM_W'(mag15[idx_q]) << PRE_SH) + NUM_W'(root >> 1);
	assign div_t   = {rem_q, num_q[QUO_W-1]};
	assign div_r   = {1'b0, root};
	assign div_ge  = div_t >= div_r;
	assign quo_fin = {quo_q[QUO_W-2:0], div_ge};
	assign quo_clip = (quo_fin > UNIT_ONE) ? UNIT_ONE : quo_fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			N_IDLE:     if (start) state_d = N_SHIFT;
			N_SHIFT: begin
				if (!wide) state_d = all_zero ? N_IDLE : N_SQUARE;
			end
			N_SQUARE:   if (idx_q == 2'd2) state_d = N_ROOT;
			N_ROOT:     if (bit_q[0]) state_d = N_DIV_LOAD;
			N_DIV_LOAD: state_d = N_DIV;
			N_DIV: begin
				if (cnt_q == '0) state_d = (idx_q == 2'd2) ? N_IDLE : N_DIV_LOAD;
			end
			default:    state_d = N_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ((state_q == N_SHIFT) && !wide && all_zero)
				|| ((state_q == N_DIV) && (cnt_q == '0) && (idx_q == 2'd2));
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			N_IDLE: begin
				if (start) begin
					for (int i = 0; i < 3; i++) begin
						neg_q[i] <= dir_a[i][DIR_WIDTH-1];
						mag_q[i] <= dir_a[i][DIR_WIDTH-1] ? (~dir_a[i] + 1'b1) : dir_a[i];
					end
				end
			end
			N_SHIFT: begin
				idx_q <= 2'd0;
				ss_q  <= '0;
				if (wide) begin
					for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
				end else if (all_zero) begin
					for (int i = 0; i < 3; i++) unit_q[i] <= '0;
				end
			end
			N_SQUARE: begin
				ss_q  <= ss_nxt;
				if (idx_q == 2'd2) begin
					rad_q  <= {ss_nxt, {PRE_SH{1'b0}}};
					root_q <= '0;
					bit_q  <= RAD_W'(1) << (RAD_W - 2);
					idx_q  <= 2'd0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
			N_ROOT: begin
				// one root bit per cycle
				if (rad_q >= trial) begin
					rad_q  <= rad_q - trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			N_DIV_LOAD: begin
				rem_q <= ROOT_W'(num >> QUO_W);
				num_q <= num[QUO_W-1:0];
				quo_q <= '0;
				cnt_q <= CNT_W'(QUO_W - 1);
			end
			N_DIV: begin
				rem_q <= div_ge ? ROOT_W'(div_t - div_r) : div_t[ROOT_W-1:0];
				quo_q <= quo_fin;
				num_q <= num_q << 1;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					unit_q[idx_q] <= neg_q[idx_q] ? -$signed(UNIT_W'(quo_clip))
						: $signed(UNIT_W'(quo_clip));
					idx_q <= idx_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign unit_x = unit_q[0];
	assign unit_y = unit_q[1];
	assign unit_z = unit_q[2];

endmodule

`default_nettype wire

@@ sv/shce_dp.sv @@
// datapath: normalization unit, basis table with shared multiplier, channel sums, output register
// depends on shce_pkg and shce_norm
`default_nettype none

module shce_dp #(
	parameter int DIR_WIDTH  = 16,
	parameter int COEF_WIDTH = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire shce_pkg::cmd_t                       cmd,
	output shce_pkg::stat_t                           stat,
	input  wire logic [1:0]                           degree,
	input  wire logic signed [DIR_WIDTH-1:0]          dir_x,
	input  wire logic signed [DIR_WIDTH-1:0]          dir_y,
	input  wire logic signed [DIR_WIDTH-1:0]          dir_z,
	input  wire logic signed [COEF_WIDTH-1:0]         coef_red,
	input  wire logic signed [COEF_WIDTH-1:0]         coef_green,
	input  wire logic signed [COEF_WIDTH-1:0]         coef_blue,
	input  wire logic                                 out_ready,
	output logic                                      out_valid,
	output logic signed [shce_pkg::OUT_W-1:0]         red,
	output logic signed [shce_pkg::OUT_W-1:0]         green,
	output logic signed [shce_pkg::OUT_W-1:0]         blue,
	output logic                                      saturated
);
	import shce_pkg::*;

	localparam int PW = COEF_WIDTH + BASIS_W;
	localparam int EW = (PW > SUM_W) ? PW : SUM_W;

	logic signed [UNIT_W-1:0]  ux, uy, uz;
	logic                      norm_done;
	logic signed [UNIT_W-1:0]  xx_q, yy_q, zz_q, xy_q, yz_q, xz_q;
	logic signed [BASIS_W-1:0] bas_q [1:N_BASIS-1];
	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [2*MUL_W-1:0] mul_p, mul_r;
	logic signed [BASIS_W-1:0] mres;
	logic [3:0]                idx_q;
	logic [1:0]                deg_eff;
	logic signed [BASIS_W-1:0] bsel;
	logic signed [COEF_WIDTH-1:0] coef [3];
	logic signed [SUM_W-1:0]   sum_q [3];
	logic signed [SUM_W-1:0]   sum_add [3];
	logic signed [PW-1:0]      cprod [3];
	logic signed [EW-1:0]      cprod_x [3];
	logic signed [SUM_W:0]     sum_rnd [3];
	logic signed [22:0]        ch_v [3];
	logic signed [OUT_W-1:0]   ch_out [3];
	logic [2:0]                ch_sat;
	logic                      out_valid_q, sat_q;
	logic signed [OUT_W-1:0]   out_q [3];

	shce_norm #(.DIR_WIDTH(DIR_WIDTH)) u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.load_dir),
		.dir_x  (dir_x),
		.dir_y  (dir_y),
		.dir_z  (dir_z),
		.done   (norm_done),
		.unit_x (ux),
		.unit_y (uy),
		.unit_z (uz)
	);

	// basis table, one multiply per step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.bstep)
			BS_XX: begin mul_a = MUL_W'(ux); mul_b = MUL_W'(ux); end
			BS_YY: begin mul_a = MUL_W'(uy); mul_b = MUL_W'(uy); end
			BS_ZZ: begin mul_a = MUL_W'(uz); mul_b = MUL_W'(uz); end
			BS_XY: begin mul_a = MUL_W'(ux); mul_b = MUL_W'(uy); end
			BS_YZ: begin mul_a = MUL_W'(uy); mul_b = MUL_W'(uz); end
			BS_XZ: begin mul_a = MUL_W'(ux); mul_b = MUL_W'(uz); end
			BS_B1: begin mul_a = K_C1; mul_b = MUL_W'(uy); end
			BS_B2: begin mul_a = K_C1; mul_b = MUL_W'(uz); end
			BS_B3: begin mul_a = K_C1; mul_b = MUL_W'(ux); end
			BS_B4: begin mul_a = K_C21; mul_b = MUL_W'(xy_q); end
			BS_B5: begin mul_a = K_C21; mul_b = MUL_W'(yz_q); end
			BS_B6: begin
				mul_a = K_C20;
				mul_b = (MUL_W'(zz_q) <<< 1) - MUL_W'(xx_q) - MUL_W'(yy_q);
			end
			BS_B7: begin mul_a = K_C21; mul_b = MUL_W'(xz_q); end
			BS_B8: begin mul_a = K_C24; mul_b = MUL_W'(xx_q) - MUL_W'(yy_q); end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign mul_r = (mul_p + (2*MUL_W)'(1 << (FRAC_W - 1))) >>> FRAC_W;
	assign mres  = mul_r[BASIS_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.bstep_en) begin
			case (cmd.bstep)
				BS_XX: xx_q <= mres;
				BS_YY: yy_q <= mres;
				BS_ZZ: zz_q <= mres;
				BS_XY: xy_q <= mres;
				BS_YZ: yz_q <= mres;
				BS_XZ: xz_q <= mres;
				default: ;
			endcase
		end
	end

	// reset clears every basis value past the constant one, as for a zero direction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i < N_BASIS; i++) bas_q[i] <= '0;
		end else if (cmd.bstep_en) begin
			case (cmd.bstep)
				BS_B1: bas_q[1] <= mres;
				BS_B2: bas_q[2] <= mres;
				BS_B3: bas_q[3] <= mres;
				BS_B4: bas_q[4] <= mres;
				BS_B5: bas_q[5] <= mres;
				BS_B6: bas_q[6] <= mres;
				BS_B7: bas_q[7] <= mres;
				BS_B8: bas_q[8] <= mres;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx_q)
			4'd0:    bsel = K_C0;
			4'd1:    bsel = bas_q[1];
			4'd2:    bsel = bas_q[2];
			4'd3:    bsel = bas_q[3];
			4'd4:    bsel = bas_q[4];
			4'd5:    bsel = bas_q[5];
			4'd6:    bsel = bas_q[6];
			4'd7:    bsel = bas_q[7];
			4'd8:    bsel = bas_q[8];
			default: bsel = '0;
		endcase
	end

	assign coef[0] = coef_red;
	assign coef[1] = coef_green;
	assign coef[2] = coef_blue;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cprod[i]   = coef[i] * bsel;
			cprod_x[i] = EW'(cprod[i]);
			sum_add[i] = sum_q[i] + $signed(cprod_x[i][SUM_W-1:0]);
			sum_rnd[i] = (SUM_W+1)'(sum_q[i]) + (SUM_W+1)'(1 << (FRAC_W - 1));
			ch_v[i]    = sum_rnd[i][SUM_W:FRAC_W];
			ch_sat[i]  = (ch_v[i] > OUT_MAX) || (ch_v[i] < OUT_MIN);
			if (ch_v[i] > OUT_MAX)      ch_out[i] = OUT_MAX[OUT_W-1:0];
			else if (ch_v[i] < OUT_MIN) ch_out[i] = OUT_MIN[OUT_W-1:0];
			else                        ch_out[i] = ch_v[i][OUT_W-1:0];
		end
	end

	assign deg_eff = (degree > DEGREE_RESET) ? DEGREE_RESET : degree;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			for (int i = 0; i < 3; i++) sum_q[i] <= '0;
		end else if (cmd.load_dir || cmd.emit) begin
			idx_q <= '0;
			for (int i = 0; i < 3; i++) sum_q[i] <= '0;
		end else if (cmd.acc) begin
			for (int i = 0; i < 3; i++) sum_q[i] <= sum_add[i];
			if (!stat.last_coef) idx_q <= idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			for (int i = 0; i < 3; i++) out_q[i] <= ch_out[i];
			sat_q <= |ch_sat;
		end
	end

	assign stat.norm_done = norm_done;
	assign stat.last_coef = (5'(idx_q) + 5'd1) >= 5'(coef_count(deg_eff));
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign red       = out_q[0];
	assign green     = out_q[1];
	assign blue      = out_q[2];
	assign saturated = sat_q;

endmodule

`default_nettype wire

@@ sv/shce_ctrl.sv @@
// controller state machine: input handshake and sequencing of normalization, basis and emit
// depends on shce_pkg
`default_nettype none

module shce_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  operation,
	input  wire shce_pkg::stat_t       stat,
	output shce_pkg::cmd_t             cmd
);
	import shce_pkg::*;

	ctrl_state_t state_q, state_d;
	bstep_t      step_q;
	logic        accept;

	assign in_ready = (state_q == C_IDLE);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			step_q  <= BS_XX;
		end else begin
			state_q <= state_d;
			if (state_q == C_BASIS && step_q != BS_B8) begin
				step_q <= bstep_t'(step_q + 4'd1);
			end else begin
				step_q <= BS_XX;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.bstep = step_q;
		case (state_q)
			C_IDLE: begin
				if (accept) begin
					if (operation == OP_DIR) begin
						cmd.load_dir = 1'b1;
						state_d = C_NORM;
					end else begin
						cmd.acc = 1'b1;
						if (stat.last_coef) state_d = C_EMIT;
					end
				end
			end
			C_NORM: begin
				if (stat.norm_done) state_d = C_BASIS;
			end
			C_BASIS: begin
				cmd.bstep_en = 1'b1;
				if (step_q == BS_B8) state_d = C_IDLE;
			end
			C_EMIT: begin
				// wait for the output register to drain
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d = C_IDLE;
				end
			end
			default: state_d = C_IDLE;
		endcase
	end

endmodule

`default_nettype wire

@@ sv/sh_color_evaluator.sv @@
// Evaluates view-dependent RGB colour from real spherical harmonics of degree 0 to 2.
// A transaction with operation 0 carries a direction: it goes through prescale halvings
// (0 to DIR_WIDTH-15), then, unless it is zero, the one-bit-per-cycle square root and the
// restoring divider for each component, then the 14-step basis table build on one shared
// multiplier, with the input closed meanwhile. A coefficient transaction is summed as it
// is accepted; after the last of a point, an emit state loads the output register.
// Top level: degree register on the APB port, shce_ctrl and shce_dp; depends on shce_pkg.
`default_nettype none

module sh_color_evaluator #(
	parameter int DIR_WIDTH  = 16,
	parameter int COEF_WIDTH = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [2:0]                      paddr,
	input  wire logic [31:0]                     pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            operation,
	input  wire logic signed [DIR_WIDTH-1:0]     dir_x,
	input  wire logic signed [DIR_WIDTH-1:0]     dir_y,
	input  wire logic signed [DIR_WIDTH-1:0]     dir_z,
	input  wire logic signed [COEF_WIDTH-1:0]    coef_red,
	input  wire logic signed [COEF_WIDTH-1:0]    coef_green,
	input  wire logic signed [COEF_WIDTH-1:0]    coef_blue,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic signed [shce_pkg::OUT_W-1:0]    red,
	output logic signed [shce_pkg::OUT_W-1:0]    green,
	output logic signed [shce_pkg::OUT_W-1:0]    blue,
	output logic                                 saturated
);
	import shce_pkg::*;

	logic [1:0] degree_q;
	logic       reg_hit;
	cmd_t       cmd;
	stat_t      stat;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == REG_DEGREE) && (paddr[1:0] == 2'b00);
	assign prdata  = reg_hit ? {30'd0, degree_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= DEGREE_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			degree_q <= pwdata[1:0];
		end
	end

	shce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.stat      (stat),
		.cmd       (cmd)
	);

	shce_dp #(.DIR_WIDTH(DIR_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.degree     (degree_q),
		.dir_x      (dir_x),
		.dir_y      (dir_y),
		.dir_z      (dir_z),
		.coef_red   (coef_red),
		.coef_green (coef_green),
		.coef_blue  (coef_blue),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.saturated  (saturated)
	);

`ifndef NO_ASSERTIONS
	// a direction transaction keeps the input closed while it is normalized
	a_dir_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && operation == OP_DIR) |=> !in_ready)
		else $error("input reopened right after a direction transaction");

	// a new result only comes from an emit command
	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.emit))
		else $error("result appeared without an emit");

	// emit never overwrites a result still waiting
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid || out_ready))
		else $error("emit over a pending result");
`endif

endmodule

`default_nettype wire
